/* sv/rclfp_pkg.sv */
// Shared constants, command/status structs and the CRC step for the frame parser.
// No dependencies; every other file imports this package.
package rclfp_pkg;

	localparam int MAX_FRAME_LEN = 64;
	localparam int MIN_FRAME_LEN = 5;
	localparam int STORE_DEPTH   = 64;
	localparam int STORE_AW      = $clog2(STORE_DEPTH);
	localparam int POS_W         = $clog2(MAX_FRAME_LEN - 2);
	localparam int CHANNELS      = 16;
	localparam int CHAN_BITS     = 11;
	localparam int CH_W          = $clog2(CHANNELS);
	localparam int BITPOS_W      = 8;

	localparam logic [7:0] SYNC_BYTE = 8'hC8;
	localparam logic [7:0] CRC_POLY  = 8'hD5;
	localparam logic [7:0] KIND_RC   = 8'h16;
	localparam logic [7:0] KIND_LINK = 8'h14;
	localparam logic [7:0] LINK_MIN_LEN = 8'd6;

	localparam logic [7:0] QUALITY_FLOOR_RST  = 8'd20;
	localparam logic [7:0] SIGNAL_CEILING_RST = 8'd100;
	localparam logic [7:0] QUALITY_RST        = 8'd100;
	localparam logic [7:0] RSSI_RST           = 8'd99;

	localparam logic CFG_QUALITY_FLOOR  = 1'b0;
	localparam logic CFG_SIGNAL_CEILING = 1'b1;

	localparam logic KIND_OUT_CHANNEL = 1'b0;
	localparam logic KIND_OUT_LINK    = 1'b1;

	typedef struct packed {
		logic       frame_start;
		logic       len_load;
		logic       kind_load;
		logic       crc_step;
		logic       store_wr;
		logic       pos_inc;
		logic       rd_link;
		logic [1:0] rd_off;
		logic       cap;
		logic [1:0] cap_sel;
		logic       link_load;
		logic       ch_clear;
		logic       ch_next;
	} dp_cmd_t;

	typedef struct packed {
		logic sync_hit;
		logic len_ok;
		logic pay_end;
		logic crc_ok;
		logic kind_rc;
		logic kind_link;
		logic link_long;
		logic ch_last;
	} dp_sts_t;

	typedef struct packed {
		logic                 result_kind;
		logic [CH_W-1:0]      channel_index;
		logic [CHAN_BITS-1:0] channel_value;
		logic [7:0]           link_qual;
		logic [7:0]           signal_strength;
		logic                 failsafe;
		logic                 last;
	} res_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* sv/rclfp_if.sv */
// Request channel interfaces: received bytes in, parsed results out.
// Depends on rclfp_pkg for field widths.
interface rclfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rclfp_res_if import rclfp_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic                 result_kind;
	logic [CH_W-1:0]      channel_index;
	logic [CHAN_BITS-1:0] channel_value;
	logic [7:0]           link_qual;
	logic [7:0]           signal_strength;
	logic                 failsafe;
	logic                 last;

	modport source (output valid, output result_kind, output channel_index,
		output channel_value, output link_qual, output signal_strength,
		output failsafe, output last, input ready);
	modport sink (input valid, input result_kind, input channel_index,
		input channel_value, input link_qual, input signal_strength,
		input failsafe, input last, output ready);
endinterface

/* sv/rc_link_frame_parser.sv */
// Top level of the RC link frame parser: joins controller and datapath to the
// byte and result request channels and the configuration write port.
// Depends on rclfp_pkg, rclfp_if, rclfp_ctrl and rclfp_dp.
// Ready stays high while a frame is parsed and drops while a good frame's results are read out.
// A good channel frame yields 16 results, each after the store-read states RD0 to RD3
// plus the wait in ST_OUT for the result to be taken.
// A good link frame of length 6 or more yields one result after the states LK0 to LK2.
// Reset is asynchronous, active low; the payload store reads as zero after reset
// through per-entry valid bits, with no clearing pass.
module rc_link_frame_parser import rclfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rclfp_byte_if.sink rx,
	rclfp_res_if.source res,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	res_t    res_d;

	rclfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx.valid),
		.rx_ready  (rx.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rclfp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res_d)
	);

	assign res.result_kind     = res_d.result_kind;
	assign res.channel_index   = res_d.channel_index;
	assign res.channel_value   = res_d.channel_value;
	assign res.link_qual       = res_d.link_qual;
	assign res.signal_strength = res_d.signal_strength;
	assign res.failsafe        = res_d.failsafe;
	assign res.last            = res_d.last;

endmodule

/* sv/rclfp_dp.sv */
// Datapath: frame registers, CRC, payload store with valid bits, channel unpacker,
// link statistics and configuration registers. Depends on rclfp_pkg.
module rclfp_dp import rclfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  dp_cmd_t    cmd,
	output dp_sts_t    sts,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output res_t       res
);

	logic [7:0]              len_q;
	logic [7:0]              kind_q;
	logic [POS_W-1:0]        pos_q;
	logic [7:0]              crc_q;
	logic [7:0]              store_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0]  vld_q;
	logic [7:0]              rd_data_q;
	logic                    rd_vld_q;
	logic [23:0]             w_q;
	logic [CH_W-1:0]         ch_q;
	logic [BITPOS_W-1:0]     bitpos_q;
	logic [7:0]              quality_q;
	logic [7:0]              rssi_q;
	logic                    lost_q;
	logic [7:0]              floor_q;
	logic [7:0]              ceil_q;

	logic [STORE_AW-1:0]     rd_addr;
	logic [STORE_AW-1:0]     wr_addr;
	logic [7:0]              rd_byte;
	logic [23:0]             w_shift;

	assign wr_addr = STORE_AW'(pos_q);
	assign rd_addr = cmd.rd_link ? STORE_AW'(cmd.rd_off)
		: STORE_AW'(bitpos_q[BITPOS_W-1:3]) + STORE_AW'(cmd.rd_off);
	assign rd_byte = rd_vld_q ? rd_data_q : 8'd0;
	assign w_shift = w_q >> bitpos_q[2:0];

	always_comb begin
		sts.sync_hit  = (rx_byte == SYNC_BYTE);
		sts.len_ok    = (rx_byte >= 8'(MIN_FRAME_LEN)) && (rx_byte <= 8'(MAX_FRAME_LEN));
		sts.pay_end   = ((8'(pos_q) + 8'd3) >= len_q);
		sts.crc_ok    = (crc_q == rx_byte);
		sts.kind_rc   = (kind_q == KIND_RC);
		sts.kind_link = (kind_q == KIND_LINK);
		sts.link_long = (len_q >= LINK_MIN_LEN);
		sts.ch_last   = (ch_q == CH_W'(CHANNELS - 1));
	end

	always_comb begin
		res.result_kind     = sts.kind_link ? KIND_OUT_LINK : KIND_OUT_CHANNEL;
		res.channel_index   = sts.kind_link ? '0 : ch_q;
		res.channel_value   = sts.kind_link ? '0 : w_shift[CHAN_BITS-1:0];
		res.link_qual       = quality_q;
		res.signal_strength = rssi_q;
		res.failsafe        = lost_q;
		res.last            = sts.kind_link | sts.ch_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			store_q[wr_addr] <= rx_byte;
		end
		rd_data_q <= store_q[rd_addr];
		if (cmd.cap) begin
			case (cmd.cap_sel)
				2'd0: w_q[7:0]   <= rd_byte;
				2'd1: w_q[15:8]  <= rd_byte;
				2'd2: w_q[23:16] <= rd_byte;
				default: w_q     <= w_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			len_q     <= '0;
			kind_q    <= '0;
			pos_q     <= '0;
			crc_q     <= '0;
			ch_q      <= '0;
			bitpos_q  <= '0;
			quality_q <= QUALITY_RST;
			rssi_q    <= RSSI_RST;
			lost_q    <= 1'b0;
			floor_q   <= QUALITY_FLOOR_RST;
			ceil_q    <= SIGNAL_CEILING_RST;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (cmd.store_wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.frame_start) begin
				len_q <= '0;
				pos_q <= '0;
				crc_q <= '0;
			end
			if (cmd.len_load) begin
				len_q <= rx_byte;
			end
			if (cmd.kind_load) begin
				kind_q <= rx_byte;
			end
			if (cmd.crc_step) begin
				crc_q <= crc8_step(crc_q, rx_byte);
			end
			if (cmd.pos_inc) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (cmd.ch_clear) begin
				ch_q     <= '0;
				bitpos_q <= '0;
			end else if (cmd.ch_next) begin
				ch_q     <= ch_q + CH_W'(1);
				bitpos_q <= bitpos_q + BITPOS_W'(CHAN_BITS);
			end
			if (cmd.link_load) begin
				quality_q <= w_q[7:0];
				rssi_q    <= rd_byte;
				lost_q    <= (w_q[7:0] < floor_q) || (rd_byte > ceil_q);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_QUALITY_FLOOR:  floor_q <= cfg_data;
					CFG_SIGNAL_CEILING: ceil_q  <= cfg_data;
					default:            floor_q <= floor_q;
				endcase
			end
		end
	end

endmodule

/* sv/rclfp_ctrl.sv */
// Controller: frame phase tracking and the read/emit sequencer for finished frames.
// Drives datapath commands from its status. Depends on rclfp_pkg.
module rclfp_ctrl import rclfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    rx_valid,
	output logic    rx_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		PH_SYNC,
		PH_LEN,
		PH_TYPE,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_LK0,
		ST_LK1,
		ST_LK2,
		ST_OUT
	} state_t;

	phase_t phase_q;
	state_t state_q;
	logic   rx_acc;
	logic   out_acc;

	assign rx_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign rx_acc    = rx_valid && rx_ready;
	assign out_acc   = out_valid && out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (rx_acc) begin
					case (phase_q)
						PH_SYNC:    cmd.frame_start = sts.sync_hit;
						PH_LEN:     cmd.len_load = 1'b1;
						PH_TYPE: begin
							cmd.kind_load = 1'b1;
							cmd.crc_step  = 1'b1;
						end
						PH_PAYLOAD: begin
							cmd.store_wr = 1'b1;
							cmd.crc_step = 1'b1;
							cmd.pos_inc  = !sts.pay_end;
						end
						PH_CRC:     cmd.ch_clear = 1'b1;
						default:    cmd = '0;
					endcase
				end
			end
			ST_RD0: cmd.rd_off = 2'd0;
			ST_RD1: begin
				cmd.rd_off  = 2'd1;
				cmd.cap     = 1'b1;
				cmd.cap_sel = 2'd0;
			end
			ST_RD2: begin
				cmd.rd_off  = 2'd2;
				cmd.cap     = 1'b1;
				cmd.cap_sel = 2'd1;
			end
			ST_RD3: begin
				cmd.cap     = 1'b1;
				cmd.cap_sel = 2'd2;
			end
			ST_LK0: begin
				cmd.rd_link = 1'b1;
				cmd.rd_off  = 2'd0;
			end
			ST_LK1: begin
				cmd.rd_link = 1'b1;
				cmd.rd_off  = 2'd2;
				cmd.cap     = 1'b1;
				cmd.cap_sel = 2'd0;
			end
			ST_LK2: cmd.link_load = 1'b1;
			ST_OUT: cmd.ch_next = out_acc && sts.kind_rc;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rx_acc) begin
						case (phase_q)
							PH_SYNC: begin
								if (sts.sync_hit) begin
									phase_q <= PH_LEN;
								end
							end
							PH_LEN:     phase_q <= sts.len_ok ? PH_TYPE : PH_SYNC;
							PH_TYPE:    phase_q <= PH_PAYLOAD;
							PH_PAYLOAD: begin
								if (sts.pay_end) begin
									phase_q <= PH_CRC;
								end
							end
							PH_CRC: begin
								phase_q <= PH_SYNC;
								if (sts.crc_ok && sts.kind_rc) begin
									state_q <= ST_RD0;
								end else if (sts.crc_ok && sts.kind_link && sts.link_long) begin
									state_q <= ST_LK0;
								end
							end
							default: phase_q <= PH_SYNC;
						endcase
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_RD3;
				ST_RD3: state_q <= ST_OUT;
				ST_LK0: state_q <= ST_LK1;
				ST_LK1: state_q <= ST_LK2;
				ST_LK2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_acc) begin
						if (sts.kind_link || sts.ch_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RD0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_ready && out_valid))
		else $error("byte request taken while a result is pending");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_RD3 || $past(state_q) == ST_LK2))
		else $error("result raised without a completed store read");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && (sts.kind_link || sts.ch_last)) |=> rx_ready)
		else $error("parser not ready after the final result");

	a_phase_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && phase_q == PH_CRC) |=> phase_q == PH_SYNC)
		else $error("phase did not return to sync hunt after check byte");

	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sts.kind_rc || sts.kind_link))
		else $error("result for a frame type that yields none");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for rc_link_frame_parser: a directed byte table, then random frames
// under several threshold settings, with every result predicted and checked in order.
// Depends on rclfp_pkg and the request channel interfaces in rclfp_if.
module tb_top;
	import rclfp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS    = 40;
	localparam int PHASE_BYTES = 80;

	typedef enum logic [2:0] {
		HUNT_SYNC, TAKE_LEN, TAKE_KIND, TAKE_PAYLOAD, TAKE_CHECK
	} parse_phase_t;

	typedef enum logic [1:0] {B_RAW, B_CRC_OK, B_CRC_BAD} byte_src_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_LINK} row_chk_t;

	typedef struct packed {
		logic [7:0] b;
		byte_src_t  src;
		row_chk_t   chk;
		logic [7:0] lq;
		logic [7:0] rs;
		logic       fs;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	rclfp_byte_if rx_if ();
	rclfp_res_if  res_if ();

	rc_link_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	parse_phase_t pm_phase = HUNT_SYNC;
	logic [7:0]   pm_len   = 8'd0;
	logic [7:0]   pm_kind  = 8'd0;
	int           pm_pos   = 0;
	logic [7:0]   calc_crc = 8'd0;
	logic [7:0]   pay_mem [STORE_DEPTH];
	logic [7:0]   cur_q    = QUALITY_RST;
	logic [7:0]   cur_rssi = RSSI_RST;
	logic         cur_lost = 1'b0;
	logic [7:0]   qfloor   = QUALITY_FLOOR_RST;
	logic [7:0]   sceil    = SIGNAL_CEILING_RST;

	res_t fresh_results [$];
	res_t expected_results [$];

	int  err_cnt     = 0;
	int  n_checked   = 0;
	int  n_chan      = 0;
	int  n_link      = 0;
	int  sent_cnt    = 0;
	int  frames_sent = 0;
	int  cycle_cnt   = 0;
	int  hold_cnt    = 0;
	bit  calm        = 1'b0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'hC8, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h04, B_RAW, CHK_NONE,  8'h00, 8'h00, 1'b0},
		'{8'hC8, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h41, B_RAW, CHK_NONE,  8'h00, 8'h00, 1'b0},
		'{8'hC8, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h06, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h14, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'hFF, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'hC8, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_CRC_OK, CHK_LINK, 8'hFF, 8'h00, 1'b0},
		'{8'hC8, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h05, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h16, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'hFF, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'hFF, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'hFF, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_CRC_OK, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'hC8, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h05, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h14, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_CRC_OK, CHK_NONE, 8'h00, 8'h00, 1'b0},
		'{8'hC8, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h05, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h16, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_CRC_BAD, CHK_NONE, 8'h00, 8'h00, 1'b0},
		'{8'hC8, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h05, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'hFF, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'hFF, B_RAW, CHK_MODEL, 8'h00, 8'h00, 1'b0},
		'{8'h00, B_CRC_OK, CHK_NONE, 8'h00, 8'h00, 1'b0}
	};

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= 40) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	function automatic logic [7:0] crc_d5(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) begin
			c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		res_t                      r;
		logic [8*STORE_DEPTH-1:0] flat;
		fresh_results.delete();
		case (pm_phase)
			HUNT_SYNC: begin
				if (b == SYNC_BYTE) begin
					pm_phase = TAKE_LEN;
					pm_len   = 8'd0;
					pm_pos   = 0;
					calc_crc = 8'd0;
				end
			end
			TAKE_LEN: begin
				pm_len   = b;
				pm_phase = (b >= MIN_FRAME_LEN && b <= MAX_FRAME_LEN) ? TAKE_KIND : HUNT_SYNC;
			end
			TAKE_KIND: begin
				pm_kind  = b;
				calc_crc = crc_d5(calc_crc, b);
				pm_phase = TAKE_PAYLOAD;
			end
			TAKE_PAYLOAD: begin
				if (pm_pos < STORE_DEPTH) begin
					pay_mem[pm_pos] = b;
				end
				calc_crc = crc_d5(calc_crc, b);
				if (pm_pos + 3 >= int'(pm_len)) begin
					pm_phase = TAKE_CHECK;
				end else begin
					pm_pos++;
				end
			end
			default: begin
				pm_phase = HUNT_SYNC;
				if (calc_crc == b && pm_kind == KIND_RC) begin
					for (int k = 0; k < STORE_DEPTH; k++) begin
						flat[k*8 +: 8] = pay_mem[k];
					end
					for (int ch = 0; ch < CHANNELS; ch++) begin
						r.result_kind     = KIND_OUT_CHANNEL;
						r.channel_index   = CH_W'(ch);
						r.channel_value   = flat[ch*CHAN_BITS +: CHAN_BITS];
						r.link_qual       = cur_q;
						r.signal_strength = cur_rssi;
						r.failsafe        = cur_lost;
						r.last            = (ch == CHANNELS - 1);
						fresh_results = {fresh_results, r};
					end
				end else if (calc_crc == b && pm_kind == KIND_LINK && pm_len >= LINK_MIN_LEN) begin
					cur_q    = pay_mem[0];
					cur_rssi = pay_mem[2];
					cur_lost = (cur_q < qfloor) || (cur_rssi > sceil);
					r.result_kind     = KIND_OUT_LINK;
					r.channel_index   = '0;
					r.channel_value   = '0;
					r.link_qual       = cur_q;
					r.signal_strength = cur_rssi;
					r.failsafe        = cur_lost;
					r.last            = 1'b1;
					fresh_results = {fresh_results, r};
				end
			end
		endcase
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 9);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic int sender_gap();
		if (calm || $urandom_range(0, 99) < 55) begin
			return 0;
		end
		return idle_len();
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit keep);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		sent_cnt++;
		parse_byte(b);
		if (keep) begin
			expected_results = {expected_results, fresh_results};
		end
	endtask

	task automatic drain();
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == CFG_QUALITY_FLOOR) begin
			qfloor = val;
		end else begin
			sceil = val;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame();
		int         pick;
		int         len;
		int         cut;
		bit         near;
		logic [7:0] kind;
		logic [7:0] b;
		calm = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 9) < 3) begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b1);
		end
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			kind = KIND_RC;
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				len = 24;
			end else if (pick < 75) begin
				len = MAX_FRAME_LEN;
			end else begin
				len = $urandom_range(MIN_FRAME_LEN, MAX_FRAME_LEN);
			end
		end else if (pick < 80) begin
			kind = KIND_LINK;
			len  = ($urandom_range(0, 4) == 0) ? MIN_FRAME_LEN : $urandom_range(6, 15);
		end else begin
			kind = 8'($urandom_range(0, 255));
			len  = $urandom_range(MIN_FRAME_LEN, 12);
		end
		if ($urandom_range(0, 99) < 8) begin
			len = $urandom_range(0, 1) ? $urandom_range(0, MIN_FRAME_LEN - 1)
				: $urandom_range(MAX_FRAME_LEN + 1, 255);
		end
		cut  = ($urandom_range(0, 99) < 5) ? $urandom_range(0, len - 3) : -1;
		near = ($urandom_range(0, 99) < 40);
		send_byte(SYNC_BYTE, 1'b1);
		send_byte(8'(len), 1'b1);
		if (len < MIN_FRAME_LEN || len > MAX_FRAME_LEN) begin
			return;
		end
		send_byte(kind, 1'b1);
		for (int i = 0; i < len - 2; i++) begin
			if (i == cut) begin
				return;
			end
			b = 8'($urandom_range(0, 255));
			if (near && i == 0) begin
				b = qfloor + 8'($urandom_range(0, 2)) - 8'd1;
			end else if (near && i == 2) begin
				b = sceil + 8'($urandom_range(0, 2)) - 8'd1;
			end
			send_byte(b, 1'b1);
		end
		b = calc_crc;
		if ($urandom_range(0, 99) < 15) begin
			b = b ^ (8'd1 << $urandom_range(0, 7));
		end
		send_byte(b, 1'b1);
		frames_sent++;
	endtask

	task automatic take_result();
		res_t want;
		n_checked++;
		if (expected_results.size() == 0) begin
			flag_error($sformatf("result %0d arrived with none expected", n_checked));
			return;
		end
		want = expected_results.pop_front();
		if (res_if.result_kind == KIND_OUT_LINK) begin
			n_link++;
		end else begin
			n_chan++;
		end
		if (res_if.result_kind !== want.result_kind || res_if.channel_index !== want.channel_index
				|| res_if.channel_value !== want.channel_value
				|| res_if.link_qual !== want.link_qual
				|| res_if.signal_strength !== want.signal_strength
				|| res_if.failsafe !== want.failsafe || res_if.last !== want.last) begin
			flag_error($sformatf({"result %0d: kind %0h/%0h idx %0d/%0d val %0h/%0h ",
				"lq %0h/%0h rssi %0h/%0h fs %0b/%0b last %0b/%0b (got/want)"}, n_checked,
				res_if.result_kind, want.result_kind, res_if.channel_index, want.channel_index,
				res_if.channel_value, want.channel_value, res_if.link_qual,
				want.link_qual, res_if.signal_strength, want.signal_strength,
				res_if.failsafe, want.failsafe, res_if.last, want.last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			take_result();
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				res_if.ready <= 1'b0;
				hold_cnt--;
			end else begin
				res_if.ready <= 1'b1;
				if (!calm && $urandom_range(0, 99) < 25) begin
					hold_cnt = idle_len();
				end
			end
		end
	end

	initial begin
		dir_row_t   row;
		res_t       typed;
		logic [7:0] b;
		int         target;
		int         mid;
		bit         pressed;
		foreach (pay_mem[k]) pay_mem[k] = 8'd0;
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'd0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_QUALITY_FLOOR;
		cfg_data      = 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_rows[i];
			case (row.src)
				B_RAW:    b = row.b;
				B_CRC_OK: b = calc_crc;
				default:  b = calc_crc ^ 8'h01;
			endcase
			send_byte(b, row.chk == CHK_MODEL);
			if (row.chk == CHK_LINK) begin
				typed.result_kind     = KIND_OUT_LINK;
				typed.channel_index   = '0;
				typed.channel_value   = '0;
				typed.link_qual       = row.lq;
				typed.signal_strength = row.rs;
				typed.failsafe        = row.fs;
				typed.last            = 1'b1;
				expected_results = {expected_results, typed};
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			repeat (12) @(posedge clk);
			case (ph)
				0: begin
					write_reg(CFG_QUALITY_FLOOR, 8'd0);
					write_reg(CFG_SIGNAL_CEILING, 8'd255);
				end
				1: begin
					write_reg(CFG_SIGNAL_CEILING, 8'd0);
					write_reg(CFG_QUALITY_FLOOR, 8'd255);
				end
				default: begin
					write_reg(CFG_QUALITY_FLOOR, 8'($urandom_range(0, 255)));
					write_reg(CFG_SIGNAL_CEILING, 8'($urandom_range(0, 255)));
				end
			endcase
			target  = sent_cnt + PHASE_BYTES;
			mid     = sent_cnt + $urandom_range(20, 80);
			pressed = 1'b0;
			while (sent_cnt < target) begin
				send_frame();
				if (!pressed && sent_cnt >= mid) begin
					drain();
					pressed = 1'b1;
				end
			end
		end

		calm = 1'b0;
		drain();
		repeat (40) @(posedge clk);
		$display("Summary: %0d bytes sent, %0d random frames, 4 threshold settings after defaults",
			sent_cnt, frames_sent);
		$display("Summary: %0d results checked, %0d channel values and %0d link updates",
			n_checked, n_chan, n_link);
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/rclfp_pkg.sv
sv/rclfp_if.sv
sv/rclfp_dp.sv
sv/rclfp_ctrl.sv
sv/rc_link_frame_parser.sv
sim/tb_top.sv
